// ===== hw/rtl/rms_pkg.sv =====
// shared constants, types and helpers for the running mean and sigma block
`default_nettype none

package rms_pkg;

    // field widths at the ports
    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 16;
    localparam int STAT_W   = 32;

    // sizing of the accumulators
    localparam int SAMPLE_BITS = 24;
    localparam int COUNT_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS + COUNT_BITS;
    localparam int PROD_BITS   = 2 * SUM_BITS;
    localparam int QUO_BITS    = SUM_BITS + FRAC_BITS;
    localparam int ROOT_BITS   = SUM_BITS + FRAC_BITS;
    localparam int RAD_BITS    = 2 * ROOT_BITS;

    localparam int MUL_STEP_W  = $clog2(SUM_BITS + 1);
    localparam int DIV_STEP_W  = $clog2(QUO_BITS + 1);
    localparam int SQRT_STEP_W = $clog2(ROOT_BITS + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_FULL = {COUNT_BITS{1'b1}};

    // operation carried by an input beat
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MEAN,
        S_ROOT,
        S_SIGMA,
        S_DONE
    } t_state;

    typedef enum logic {
        DIV_MEAN,
        DIV_SIGMA
    } t_div_sel;

    typedef struct packed {
        logic     accept;
        logic     mul_start;
        logic     div_start;
        t_div_sel div_sel;
        logic     sqrt_start;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic mul_busy;
        logic div_busy;
        logic sqrt_busy;
    } t_status;

    // quotient to the statistic field, truncated or zero extended
    function automatic logic [STAT_W-1:0] to_stat(input logic [QUO_BITS-1:0] q);
        logic [QUO_BITS+STAT_W-1:0] w;
        w = {{STAT_W{1'b0}}, q};
        return w[STAT_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] to_count(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS+COUNT_W-1:0] w;
        w = {{COUNT_W{1'b0}}, c};
        return w[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rms_if.sv =====
// valid/ready channels for samples in and statistics out
`default_nettype none

interface rms_in_if;
    import rms_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

interface rms_out_if;
    import rms_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] count;
    logic [STAT_W-1:0]  mean_q8;
    logic [STAT_W-1:0]  sigma_q8;
    logic               valid_res;
    logic               dropped;

    modport source (output valid, output count, output mean_q8, output sigma_q8,
                    output valid_res, output dropped, input ready);
    modport sink   (input valid, input count, input mean_q8, input sigma_q8,
                    input valid_res, input dropped, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rms_mul.sv =====
// shift-add multiplier forming count*sumsq and sum*sum side by side
`default_nettype none

module rms_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rms_pkg::SQ_BITS-1:0]   i_sq,
    input  wire logic [rms_pkg::COUNT_BITS-1:0] i_count,
    input  wire logic [rms_pkg::SUM_BITS-1:0]  i_sum,
    output logic                               o_busy,
    output logic [rms_pkg::PROD_BITS-1:0]      o_prod_a,
    output logic [rms_pkg::PROD_BITS-1:0]      o_prod_b
);
    import rms_pkg::*;

    logic                  r_busy;
    logic [MUL_STEP_W-1:0] r_step;
    logic [PROD_BITS-1:0]  r_mc_a, r_mc_b, r_acc_a, r_acc_b;
    logic [COUNT_BITS-1:0] r_mp_a;
    logic [SUM_BITS-1:0]   r_mp_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= MUL_STEP_W'(SUM_BITS);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == MUL_STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mc_a  <= {{COUNT_BITS{1'b0}}, i_sq};
            r_mp_a  <= i_count;
            r_mc_b  <= {{SUM_BITS{1'b0}}, i_sum};
            r_mp_b  <= i_sum;
            r_acc_a <= '0;
            r_acc_b <= '0;
        end else if (r_busy) begin
            if (r_mp_a[0]) begin
                r_acc_a <= r_acc_a + r_mc_a;
            end
            if (r_mp_b[0]) begin
                r_acc_b <= r_acc_b + r_mc_b;
            end
            r_mc_a <= {r_mc_a[PROD_BITS-2:0], 1'b0};
            r_mc_b <= {r_mc_b[PROD_BITS-2:0], 1'b0};
            r_mp_a <= {1'b0, r_mp_a[COUNT_BITS-1:1]};
            r_mp_b <= {1'b0, r_mp_b[SUM_BITS-1:1]};
        end
    end

    assign o_busy   = r_busy;
    assign o_prod_a = r_acc_a;
    assign o_prod_b = r_acc_b;

endmodule

`default_nettype wire

// ===== hw/rtl/rms_div.sv =====
// restoring divider, one quotient bit a cycle, divisor is the sample count
`default_nettype none

module rms_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [rms_pkg::QUO_BITS-1:0]   i_dividend,
    input  wire logic [rms_pkg::COUNT_BITS-1:0] i_divisor,
    output logic                                o_busy,
    output logic [rms_pkg::QUO_BITS-1:0]        o_quotient
);
    import rms_pkg::*;

    logic                  r_busy;
    logic [DIV_STEP_W-1:0] r_step;
    logic [COUNT_BITS-1:0] r_rem, r_dvs;
    logic [QUO_BITS-1:0]   r_quo;
    logic [COUNT_BITS:0]   w_shift, w_diff;
    logic                  w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[QUO_BITS-1]};
        w_ge    = w_shift >= {1'b0, r_dvs};
        w_diff  = w_shift - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= DIV_STEP_W'(QUO_BITS);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == DIV_STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[COUNT_BITS-1:0] : w_shift[COUNT_BITS-1:0];
            r_quo <= {r_quo[QUO_BITS-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== hw/rtl/rms_sqrt.sv =====
// digit-by-digit integer square root, one root bit a cycle
`default_nettype none

module rms_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rms_pkg::RAD_BITS-1:0]  i_radicand,
    output logic                               o_busy,
    output logic [rms_pkg::ROOT_BITS-1:0]      o_root
);
    import rms_pkg::*;

    logic                   r_busy;
    logic [SQRT_STEP_W-1:0] r_step;
    logic [RAD_BITS-1:0]    r_x;
    logic [ROOT_BITS+1:0]   r_rem;
    logic [ROOT_BITS-1:0]   r_root;
    logic [ROOT_BITS+3:0]   w_rem_t, w_trial, w_diff;
    logic                   w_ge;

    // bring down the next two radicand bits and try root*4+1
    always_comb begin
        w_rem_t = {r_rem, r_x[RAD_BITS-1 -: 2]};
        w_trial = {2'b00, r_root, 2'b01};
        w_ge    = w_rem_t >= w_trial;
        w_diff  = w_rem_t - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= SQRT_STEP_W'(ROOT_BITS);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == SQRT_STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[RAD_BITS-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[ROOT_BITS+1:0] : w_rem_t[ROOT_BITS+1:0];
            r_root <= {r_root[ROOT_BITS-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== hw/rtl/rms_dp.sv =====
// datapath: accumulators, arithmetic units and the result register
`default_nettype none

module rms_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rms_pkg::t_cmd                i_cmd,
    output rms_pkg::t_status                  o_status,
    input  wire logic                         i_op,
    input  wire logic [rms_pkg::SAMPLE_W-1:0] i_sample,
    output logic [rms_pkg::COUNT_W-1:0]       o_count,
    output logic [rms_pkg::STAT_W-1:0]        o_mean_q8,
    output logic [rms_pkg::STAT_W-1:0]        o_sigma_q8,
    output logic                              o_valid_res,
    output logic                              o_dropped
);
    import rms_pkg::*;

    logic [SUM_BITS-1:0]      r_sum;
    logic [SQ_BITS-1:0]       r_sq;
    logic [COUNT_BITS-1:0]    r_count;
    logic                     r_dropped;
    logic [STAT_W-1:0]        r_mean;

    logic [COUNT_W-1:0]       r_o_count;
    logic [STAT_W-1:0]        r_o_mean, r_o_sigma;
    logic                     r_o_valid_res, r_o_dropped;

    logic [SAMPLE_BITS-1:0]   w_s;
    logic [2*SAMPLE_BITS-1:0] w_s_sq;
    logic                     w_zero;

    logic                     mul_busy, div_busy, sqrt_busy;
    logic [PROD_BITS-1:0]     prod_a, prod_b, w_var;
    logic [QUO_BITS-1:0]      div_dividend, div_quo;
    logic [ROOT_BITS-1:0]     root;

    assign w_s    = i_sample[SAMPLE_BITS-1:0];
    assign w_s_sq = w_s * w_s;
    assign w_zero = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_sq    <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            if (i_op == OP_CLEAR) begin
                r_sum   <= '0;
                r_sq    <= '0;
                r_count <= '0;
            end else if (r_count != COUNT_FULL) begin
                r_sum   <= r_sum + {{COUNT_BITS{1'b0}}, w_s};
                r_sq    <= r_sq + {{COUNT_BITS{1'b0}}, w_s_sq};
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dropped <= (i_op == OP_ADD) && (r_count == COUNT_FULL);
        end
        // the divider is reused for sigma, keep the mean before that
        if (i_cmd.sqrt_start) begin
            r_mean <= to_stat(div_quo);
        end
    end

    // n*sumsq - sum^2, never negative from a consistent store
    assign w_var = (prod_a >= prod_b) ? (prod_a - prod_b) : '0;

    assign div_dividend = (i_cmd.div_sel == DIV_MEAN) ?
                          {r_sum, {FRAC_BITS{1'b0}}} : root;

    rms_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_sq     (r_sq),
        .i_count  (r_count),
        .i_sum    (r_sum),
        .o_busy   (mul_busy),
        .o_prod_a (prod_a),
        .o_prod_b (prod_b)
    );

    rms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_count),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    rms_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand ({w_var, {(2*FRAC_BITS){1'b0}}}),
        .o_busy     (sqrt_busy),
        .o_root     (root)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_count     <= to_count(r_count);
            r_o_mean      <= w_zero ? '0 : r_mean;
            r_o_sigma     <= w_zero ? '0 : to_stat(div_quo);
            r_o_valid_res <= !w_zero;
            r_o_dropped   <= r_dropped;
        end
    end

    always_comb begin
        o_status.count_zero = w_zero;
        o_status.mul_busy   = mul_busy;
        o_status.div_busy   = div_busy;
        o_status.sqrt_busy  = sqrt_busy;
    end

    assign o_count     = r_o_count;
    assign o_mean_q8   = r_o_mean;
    assign o_sigma_q8  = r_o_sigma;
    assign o_valid_res = r_o_valid_res;
    assign o_dropped   = r_o_dropped;

endmodule

`default_nettype wire

// ===== hw/rtl/rms_ctrl.sv =====
// controller: sequences update, multiply, divide and root for one beat
`default_nettype none

module rms_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output rms_pkg::t_cmd         o_cmd,
    input  wire rms_pkg::t_status i_status
);
    import rms_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = i_status.count_zero ? S_DONE : S_MEAN;
            end
            S_MEAN: begin
                if (!i_status.mul_busy && !i_status.div_busy) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (!i_status.sqrt_busy) begin
                    n_state = S_SIGMA;
                end
            end
            S_SIGMA: begin
                if (!i_status.div_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_START: begin
                if (!i_status.count_zero) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.sqrt_start = !i_status.mul_busy && !i_status.div_busy;
            end
            S_ROOT: begin
                if (!i_status.sqrt_busy) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_SIGMA;
                end
            end
            S_DONE: begin
                o_cmd.load_out = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_idle_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
        !(i_status.mul_busy || i_status.div_busy || i_status.sqrt_busy))
        else $error("arithmetic unit still busy while waiting for a beat");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_START))
        else $error("accepted beat did not start a computation");

    a_div_not_restarted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_status.div_busy)
        else $error("divider restarted while busy");

    a_load_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (o_out_valid && r_state == S_IDLE))
        else $error("result load did not present a beat");

endmodule

`default_nettype wire

// ===== hw/rtl/running_mean_and_sigma.sv =====
// running mean and population standard deviation of unsigned samples
//
// input channel i_in: op clears the store (0) or adds sample (1); one beat
// gives exactly one result beat on o_out with count, mean and sigma in Q8,
// valid_res (count nonzero) and dropped (add refused at a full count).
// sequence: a clear, or any beat that leaves the count at zero, goes from
// acceptance through S_START to S_DONE and the result register. otherwise the
// 40-step shift-add products run beside the 48-step mean divide, then a
// 48-step square root and a second 48-step divide on the same divider run.
// the divider and root unit produce a single bit per cycle, and one beat is
// worked on at a time.
// the next beat is accepted as soon as the result sits in the output register,
// so a stalled receiver holds only the finished result; the following result
// waits in the datapath until the output register is taken.
// reset (synchronous, active low) clears sum, sum of squares and count and
// leaves no result pending.
`default_nettype none

module running_mean_and_sigma (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rms_in_if.sink     i_in,
    rms_out_if.source  o_out
);
    import rms_pkg::*;

    t_cmd    cmd;
    t_status status;

    rms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    rms_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_op        (i_in.op),
        .i_sample    (i_in.sample),
        .o_count     (o_out.count),
        .o_mean_q8   (o_out.mean_q8),
        .o_sigma_q8  (o_out.sigma_q8),
        .o_valid_res (o_out.valid_res),
        .o_dropped   (o_out.dropped)
    );

endmodule

`default_nettype wire
